[src/sclx_pkg.sv]
// Package for the start-code / length-prefixed XOR deframer.
// Holds the item structs, status and register codes and the header constants.
// No dependencies; every other file of the block uses it by scoped names.
`default_nettype none

package sclx_pkg;

	// Header is start code (two bytes), type byte and two length bytes.
	localparam int HEADER_BYTES = 5;
	// At most one byte fewer than a full header is ever held between transfers.
	localparam int HOLD_BYTES   = HEADER_BYTES - 1;
	localparam int HCNT_W       = $clog2(HEADER_BYTES + 1);

	// Register values after reset.
	localparam logic [15:0] START_CODE_RST  = 16'hEFAA;
	localparam logic [15:0] MAX_LENGTH_RST  = 16'd249;
	localparam logic [15:0] STORE_LIMIT_RST = 16'd256;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_START_CODE  = 2'd0,
		REG_MAX_LENGTH  = 2'd1,
		REG_STORE_LIMIT = 2'd2
	} reg_idx_t;

	// Input item kinds.
	localparam logic KIND_BYTE  = 1'b0;
	localparam logic KIND_FLUSH = 1'b1;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_PAYLOAD = 2'd0,
		ST_GOOD    = 2'd1,
		ST_BAD     = 2'd2,
		ST_ABORT   = 2'd3
	} status_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
	} in_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  frame_type;
		logic [7:0]  payload_byte;
		logic [15:0] byte_index;
		logic [15:0] frame_length;
	} out_t;

	typedef struct packed {
		logic [15:0] start_code;
		logic [15:0] max_length;
		logic [15:0] store_limit;
	} cfg_t;

	// Outcome of one received byte while hunting for a header.
	typedef struct packed {
		logic                         hdr_ok;
		logic [HCNT_W-1:0]            count;
		logic [HOLD_BYTES-1:0][7:0]   window;
		logic [7:0]                   frame_type;
		logic [15:0]                  frame_length;
		logic [7:0]                   hdr_xor;
	} hunt_t;

endpackage

`default_nettype wire

[src/sclx_hunt.sv]
// Header hunt logic: appends a byte to the held header bytes and resyncs.
// Purely combinational; depends on sclx_pkg.
`default_nettype none

module sclx_hunt (
	input  wire logic [sclx_pkg::HOLD_BYTES-1:0][7:0] window,
	input  wire logic [sclx_pkg::HCNT_W-1:0]          count,
	input  wire logic [7:0]                           data_byte,
	input  wire sclx_pkg::cfg_t                       cfg,
	output sclx_pkg::hunt_t                           res
);

	localparam int HB = sclx_pkg::HEADER_BYTES;
	localparam int HW = sclx_pkg::HCNT_W;

	logic [HW-1:0]          cnt_c;
	logic [HW-1:0]          n;
	logic [HB-1:0][7:0]     full;
	logic [HB:0][7:0]       ext;
	logic [15:0]            len;
	logic [HB:0]            ok;
	logic [HW-1:0]          s;
	logic                   found;
	logic [HW-1:0]          rem;
	logic [HW:0]            pos;
	logic [7:0]             hi;
	logic [7:0]             lo;

	assign hi = cfg.start_code[15:8];
	assign lo = cfg.start_code[7:0];

	// Held bytes plus the new one, then the first drop count that leaves a
	// consistent prefix of a header. Each candidate is checked independently.
	always_comb begin
		cnt_c = (count > HW'(sclx_pkg::HOLD_BYTES)) ? HW'(sclx_pkg::HOLD_BYTES) : count;
		n     = cnt_c + HW'(1);
		full  = (HB * 8)'(window);
		full[cnt_c] = data_byte;
		ext   = {8'h00, full};
		len   = {full[3], full[4]};

		for (int i = 0; i < HB; i++) begin
			rem   = n - HW'(i);
			ok[i] = (HW'(i) == n) ||
			        ((HW'(i) < n) && (ext[i] == hi) &&
			         ((rem < HW'(2)) || (ext[i+1] == lo)) &&
			         ((rem < HW'(HB)) || (len <= cfg.max_length)));
		end
		ok[HB] = (n == HW'(HB));

		s     = '0;
		found = 1'b0;
		for (int i = 0; i <= HB; i++) begin
			if (!found && ok[i]) begin
				s     = HW'(i);
				found = 1'b1;
			end
		end

		rem        = n - s;
		res.hdr_ok = (rem == HW'(HB));

		// Shift out the dropped bytes; positions past the end read as zero.
		for (int j = 0; j < sclx_pkg::HOLD_BYTES; j++) begin
			pos = {1'b0, s} + (HW + 1)'(j);
			res.window[j] = (pos < (HW + 1)'(HB)) ? full[pos[HW-1:0]] : 8'h00;
		end
		res.count = rem;
		if (res.hdr_ok) begin
			res.window = '0;
			res.count  = '0;
		end

		res.frame_type   = full[2];
		res.frame_length = len;
		res.hdr_xor      = full[2] ^ full[3] ^ full[4];
	end

endmodule

`default_nettype wire

[src/sclx_parser.sv]
// Frame parser state: header window, phase, frame fields and running XOR.
// Produces at most one result per accepted item; depends on sclx_pkg, sclx_hunt.
`default_nettype none

module sclx_parser (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           acc,
	input  wire sclx_pkg::in_t  item,
	input  wire sclx_pkg::cfg_t cfg,
	output logic                push,
	output sclx_pkg::out_t      res
);

	typedef enum logic [1:0] {
		PH_HUNT    = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_CHECK   = 2'd2
	} phase_t;

	localparam int HW = sclx_pkg::HCNT_W;

	phase_t                                 phase_q, phase_d;
	logic [sclx_pkg::HOLD_BYTES-1:0][7:0]   window_q, window_d;
	logic [HW-1:0]                          count_q, count_d;
	logic [7:0]                             type_q, type_d;
	logic [15:0]                            len_q, len_d;
	logic [15:0]                            pcount_q, pcount_d;
	logic [7:0]                             xor_q, xor_d;
	sclx_pkg::hunt_t                        hunt;

	sclx_hunt u_hunt (
		.window    (window_q),
		.count     (count_q),
		.data_byte (item.data_byte),
		.cfg       (cfg),
		.res       (hunt)
	);

	// Next state and result for one accepted item.
	always_comb begin
		phase_d  = phase_q;
		window_d = window_q;
		count_d  = count_q;
		type_d   = type_q;
		len_d    = len_q;
		pcount_d = pcount_q;
		xor_d    = xor_q;

		push             = 1'b0;
		res.status       = sclx_pkg::ST_ABORT;
		res.frame_type   = type_q;
		res.payload_byte = 8'h00;
		res.byte_index   = pcount_q;
		res.frame_length = len_q;

		if (acc) begin
			if (item.kind == sclx_pkg::KIND_FLUSH) begin
				push     = (phase_q == PH_PAYLOAD) || (phase_q == PH_CHECK);
				window_d = '0;
				count_d  = '0;
				phase_d  = PH_HUNT;
			end else begin
				case (phase_q)
					PH_PAYLOAD: begin
						xor_d = xor_q ^ item.data_byte;
						if (pcount_q < cfg.store_limit) begin
							push             = 1'b1;
							res.status       = sclx_pkg::ST_PAYLOAD;
							res.payload_byte = item.data_byte;
						end
						pcount_d = pcount_q + 16'd1;
						if (pcount_d == len_q) begin
							phase_d = PH_CHECK;
						end
					end
					PH_CHECK: begin
						push       = 1'b1;
						res.status = (item.data_byte == xor_q) ?
						             sclx_pkg::ST_GOOD : sclx_pkg::ST_BAD;
						window_d   = '0;
						count_d    = '0;
						phase_d    = PH_HUNT;
					end
					default: begin
						window_d = hunt.window;
						count_d  = hunt.count;
						phase_d  = PH_HUNT;
						if (hunt.hdr_ok) begin
							type_d   = hunt.frame_type;
							len_d    = hunt.frame_length;
							pcount_d = 16'd0;
							xor_d    = hunt.hdr_xor;
							phase_d  = (hunt.frame_length == 16'd0) ? PH_CHECK : PH_PAYLOAD;
						end
					end
				endcase
			end
		end
	end

	// Parser state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			window_q <= '0;
			count_q  <= '0;
			type_q   <= '0;
			len_q    <= '0;
			pcount_q <= '0;
			xor_q    <= '0;
		end else begin
			phase_q  <= phase_d;
			window_q <= window_d;
			count_q  <= count_d;
			type_q   <= type_d;
			len_q    <= len_d;
			pcount_q <= pcount_d;
			xor_q    <= xor_d;
		end
	end

endmodule

`default_nettype wire

[src/sclx_obuf.sv]
// Two-entry result buffer: a head register that drives the output and a skid entry.
// The input side stalls only when both are full; depends on sclx_pkg.
`default_nettype none

module sclx_obuf (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire sclx_pkg::out_t push_data,
	output logic                full,
	output logic                valid,
	input  wire logic           stall,
	output sclx_pkg::out_t      data
);

	logic [1:0]     cnt_q;
	logic [1:0]     cnt_after_pop;
	logic           pop;
	sclx_pkg::out_t head_q;
	sclx_pkg::out_t skid_q;

	assign valid         = (cnt_q != 2'd0);
	assign full          = (cnt_q == 2'd2);
	assign data          = head_q;
	assign pop           = valid && !stall;
	assign cnt_after_pop = cnt_q - {1'b0, pop};

	// Occupancy count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_after_pop + {1'b0, push};
		end
	end

	// Entry data: a transfer out moves the skid entry up, a new result fills the next slot.
	always_ff @(posedge clk) begin
		if (pop && full) begin
			head_q <= skid_q;
		end
		if (push) begin
			if (cnt_after_pop == 2'd0) begin
				head_q <= push_data;
			end else begin
				skid_q <= push_data;
			end
		end
	end

endmodule

`default_nettype wire

[src/start_code_length_xor_deframer_top.sv]
// Start-code / length-prefixed frame deframer with XOR checksum, top level.
// Output: results are registered in the result buffer, whose head register drives result_item.
// Throughput: one byte or flush per cycle; byte_stall rises only when the
// two-entry result buffer is full because the result side is stalling.
// Reset: registers return to their defaults, the parser to hunting, buffer empty.
`default_nettype none

module start_code_length_xor_deframer_top (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cfg_wen,
	input  wire logic [1:0]     cfg_index,
	input  wire logic [15:0]    cfg_wdata,
	input  wire logic           byte_valid,
	output logic                byte_stall,
	input  wire sclx_pkg::in_t  byte_item,
	output logic                result_valid,
	input  wire logic           result_stall,
	output sclx_pkg::out_t      result_item
);

	sclx_pkg::cfg_t cfg_q;
	logic           buf_full;
	logic           acc;
	logic           push;
	sclx_pkg::out_t push_data;

	assign byte_stall = buf_full;
	assign acc        = byte_valid && !buf_full;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_code  <= sclx_pkg::START_CODE_RST;
			cfg_q.max_length  <= sclx_pkg::MAX_LENGTH_RST;
			cfg_q.store_limit <= sclx_pkg::STORE_LIMIT_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				sclx_pkg::REG_START_CODE:  cfg_q.start_code  <= cfg_wdata;
				sclx_pkg::REG_MAX_LENGTH:  cfg_q.max_length  <= cfg_wdata;
				sclx_pkg::REG_STORE_LIMIT: cfg_q.store_limit <= cfg_wdata;
				default: ;
			endcase
		end
	end

	sclx_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.acc    (acc),
		.item   (byte_item),
		.cfg    (cfg_q),
		.push   (push),
		.res    (push_data)
	);

	sclx_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (buf_full),
		.valid     (result_valid),
		.stall     (result_stall),
		.data      (result_item)
	);

	// A result is only produced when the buffer has room for it.
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !buf_full)
		else $error("result produced while the result buffer is full");

	// Only payload results carry a data byte.
	a_zero_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (result_item.status != sclx_pkg::ST_PAYLOAD)) |->
		(result_item.payload_byte == 8'h00))
		else $error("non-payload result with a non-zero payload byte");

	// Payload bytes are only emitted below the store limit.
	a_store_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (result_item.status == sclx_pkg::ST_PAYLOAD)) |->
		(result_item.byte_index < cfg_q.store_limit))
		else $error("payload byte emitted at or beyond the store limit");

endmodule

`default_nettype wire
